>>> sv/lpd_pkg.sv
package lpd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned WORD_W  = 16;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned ADDR_W  = 3;
    localparam int unsigned TDATA_W = 24;

    localparam logic [KIND_W-1:0] KIND_DATA     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GOOD     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_BAD_END  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TOO_LONG = 2'd3;

    localparam logic [ADDR_W-1:0] REG_START_CODE    = 3'd0;
    localparam logic [ADDR_W-1:0] REG_CLOSE_CODE    = 3'd1;
    localparam logic [ADDR_W-1:0] REG_WANTED_LABEL  = 3'd2;
    localparam logic [ADDR_W-1:0] REG_MAX_LENGTH    = 3'd3;
    localparam logic [ADDR_W-1:0] REG_DELIVER_COUNT = 3'd4;

    localparam logic [BYTE_W-1:0] RST_START_CODE    = 8'd126;
    localparam logic [BYTE_W-1:0] RST_CLOSE_CODE    = 8'd231;
    localparam logic [BYTE_W-1:0] RST_WANTED_LABEL  = 8'd5;
    localparam logic [WORD_W-1:0] RST_MAX_LENGTH    = 16'd600;
    localparam logic [WORD_W-1:0] RST_DELIVER_COUNT = 16'd600;

    typedef struct packed {
        logic [BYTE_W-1:0] start_code;
        logic [BYTE_W-1:0] close_code;
        logic [BYTE_W-1:0] wanted_label;
        logic [WORD_W-1:0] max_length;
        logic [WORD_W-1:0] deliver_count;
    } t_cfg;

    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data_byte;
        logic [WORD_W-1:0] byte_index;
    } t_result;

endpackage

>>> sv/lpd_cfg_regs.sv
module lpd_cfg_regs (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [lpd_pkg::ADDR_W-1:0] i_cfg_addr,
    input  logic [lpd_pkg::WORD_W-1:0] i_cfg_wdata,
    output lpd_pkg::t_cfg             o_cfg
);
    import lpd_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                REG_START_CODE:    n_cfg.start_code    = i_cfg_wdata[BYTE_W-1:0];
                REG_CLOSE_CODE:    n_cfg.close_code    = i_cfg_wdata[BYTE_W-1:0];
                REG_WANTED_LABEL:  n_cfg.wanted_label  = i_cfg_wdata[BYTE_W-1:0];
                REG_MAX_LENGTH:    n_cfg.max_length    = i_cfg_wdata;
                REG_DELIVER_COUNT: n_cfg.deliver_count = i_cfg_wdata;
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_code    <= RST_START_CODE;
            r_cfg.close_code    <= RST_CLOSE_CODE;
            r_cfg.wanted_label  <= RST_WANTED_LABEL;
            r_cfg.max_length    <= RST_MAX_LENGTH;
            r_cfg.deliver_count <= RST_DELIVER_COUNT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> sv/lpd_parser.sv
module lpd_parser (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [lpd_pkg::BYTE_W-1:0] i_byte,
    output logic                      o_ready,
    input  lpd_pkg::t_cfg             i_cfg,
    input  logic                      i_out_free,
    output lpd_pkg::t_result          o_res,
    output logic                      o_consume
);
    import lpd_pkg::*;

    localparam logic [2:0] PH_HUNT   = 3'd0;
    localparam logic [2:0] PH_LABEL  = 3'd1;
    localparam logic [2:0] PH_LEN_LO = 3'd2;
    localparam logic [2:0] PH_LEN_HI = 3'd3;
    localparam logic [2:0] PH_DATA   = 3'd4;
    localparam logic [2:0] PH_END    = 3'd5;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_byte;
    logic [2:0]        r_phase;
    logic [2:0]        n_phase;
    logic [WORD_W-1:0] r_len;
    logic [WORD_W-1:0] n_len;
    logic [WORD_W-1:0] r_seen;
    logic [WORD_W-1:0] n_seen;
    logic [WORD_W-1:0] seen_inc;
    t_result           res;
    logic              consume;

    assign seen_inc = r_seen + 16'd1;

    // one step of the frame parser on the held byte
    always_comb begin
        n_phase        = r_phase;
        n_len          = r_len;
        n_seen         = r_seen;
        res.valid      = 1'b0;
        res.kind       = KIND_DATA;
        res.data_byte  = '0;
        res.byte_index = '0;
        case (r_phase)
            PH_LABEL: begin
                if (r_byte == i_cfg.wanted_label) begin
                    n_phase = PH_LEN_LO;
                end else if (r_byte != i_cfg.start_code) begin
                    n_phase = PH_HUNT;
                end
            end
            PH_LEN_LO: begin
                n_len   = {{(WORD_W-BYTE_W){1'b0}}, r_byte};
                n_phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                n_len  = {r_byte, r_len[BYTE_W-1:0]};
                n_seen = '0;
                if (n_len > i_cfg.max_length) begin
                    res.valid = 1'b1;
                    res.kind  = KIND_TOO_LONG;
                    n_phase   = PH_HUNT;
                end else if (n_len == '0) begin
                    n_phase = PH_END;
                end else begin
                    n_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                if (r_seen < i_cfg.deliver_count) begin
                    res.valid      = 1'b1;
                    res.kind       = KIND_DATA;
                    res.data_byte  = r_byte;
                    res.byte_index = r_seen;
                end
                n_seen = seen_inc;
                if (seen_inc >= r_len) begin
                    n_phase = PH_END;
                end
            end
            PH_END: begin
                res.valid = 1'b1;
                res.kind  = (r_byte == i_cfg.close_code) ? KIND_GOOD : KIND_BAD_END;
                n_phase   = PH_HUNT;
            end
            default: begin
                n_phase = (r_byte == i_cfg.start_code) ? PH_LABEL : PH_HUNT;
            end
        endcase
        res.valid = res.valid & r_in_valid;
    end

    assign consume   = r_in_valid & (!res.valid | i_out_free);
    assign o_ready   = !r_in_valid | consume;
    assign o_res     = res;
    assign o_consume = consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= PH_HUNT;
            r_len      <= '0;
            r_seen     <= '0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (consume) begin
                r_phase <= n_phase;
                r_len   <= n_len;
                r_seen  <= n_seen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_byte;
        end
    end

endmodule

>>> sv/lpd_out_reg.sv
module lpd_out_reg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lpd_pkg::t_result           i_res,
    input  logic                       i_load,
    input  logic                       i_tready,
    output logic                       o_free,
    output logic                       o_tvalid,
    output logic [lpd_pkg::TDATA_W-1:0] o_tdata,
    output logic [lpd_pkg::KIND_W-1:0]  o_tuser
);
    import lpd_pkg::*;

    logic              r_valid;
    logic [KIND_W-1:0] r_kind;
    logic [BYTE_W-1:0] r_data;
    logic [WORD_W-1:0] r_index;
    logic              load;

    assign o_free = !r_valid | i_tready;
    assign load   = i_load & i_res.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind  <= i_res.kind;
            r_data  <= i_res.data_byte;
            r_index <= i_res.byte_index;
        end
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = {r_index, r_data};
    assign o_tuser  = r_kind;

endmodule

>>> sv/labelled_packet_deframer.sv
// a taken byte is held in the parser's input register, then its result is loaded into the output register
// throughput: one byte per cycle while the output register has room, set by the single parser state step
// bytes that give no result are taken at full rate even while the output stalls
// reset: synchronous active-low; parser returns to hunting, registers to defaults
// no clearing pass after reset, the block is ready in the next cycle
module labelled_packet_deframer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [lpd_pkg::BYTE_W-1:0]  s_axis_tdata,  // [7:0] rx_byte
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [lpd_pkg::TDATA_W-1:0] m_axis_tdata,  // [7:0] data_byte, [23:8] byte_index
    output logic [lpd_pkg::KIND_W-1:0]  m_axis_tuser,  // [1:0] kind
    input  logic                        i_cfg_wr_en,
    input  logic [lpd_pkg::ADDR_W-1:0]  i_cfg_addr,
    input  logic [lpd_pkg::WORD_W-1:0]  i_cfg_wdata
);
    import lpd_pkg::*;

    t_cfg    cfg;
    t_result res;
    logic    out_free;
    logic    consume;

    lpd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    lpd_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .i_byte     (s_axis_tdata),
        .o_ready    (s_axis_tready),
        .i_cfg      (cfg),
        .i_out_free (out_free),
        .o_res      (res),
        .o_consume  (consume)
    );

    lpd_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_res    (res),
        .i_load   (consume),
        .i_tready (m_axis_tready),
        .o_free   (out_free),
        .o_tvalid (m_axis_tvalid),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser)
    );

    a_no_out_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_status_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != KIND_DATA) |-> (m_axis_tdata == '0))
        else $error("status result carries nonzero data or index");

    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output register is empty");

    a_result_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res.valid && consume) |-> out_free)
        else $error("result loaded into a full output register");

endmodule

>>> verif/testbench.sv
module testbench;
    import lpd_pkg::*;

    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned PHASE_ITEMS = 180;
    localparam int unsigned NUM_PHASES  = 8;
    localparam int unsigned SETTLE      = 4;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_LABEL,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_DATA,
        PH_END
    } parse_phase_e;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_e;

    class frame_scoreboard;
        t_cfg              settings;
        parse_phase_e      state;
        logic [WORD_W-1:0] pay_len;
        logic [WORD_W-1:0] pay_seen;
        t_result           expected_q[$];
        int unsigned       fail_count;
        int unsigned       kind_count[4];

        function new();
            settings.start_code    = RST_START_CODE;
            settings.close_code    = RST_CLOSE_CODE;
            settings.wanted_label  = RST_WANTED_LABEL;
            settings.max_length    = RST_MAX_LENGTH;
            settings.deliver_count = RST_DELIVER_COUNT;
            state      = PH_HUNT;
            pay_len    = '0;
            pay_seen   = '0;
            fail_count = 0;
            foreach (kind_count[k]) kind_count[k] = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void queue_result(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] data,
                                   logic [WORD_W-1:0] idx);
            t_result r;
            r.valid      = 1'b1;
            r.kind       = kind;
            r.data_byte  = data;
            r.byte_index = idx;
            expected_q.push_back(r);
        endfunction

        // advance the parser by one accepted byte
        function void note_input(logic [BYTE_W-1:0] b);
            case (state)
                PH_LABEL: begin
                    if (b == settings.wanted_label)
                        state = PH_LEN_LO;
                    else if (b != settings.start_code)
                        state = PH_HUNT;
                end
                PH_LEN_LO: begin
                    pay_len = {8'h00, b};
                    state   = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    pay_len[15:8] = b;
                    pay_seen      = '0;
                    if (pay_len > settings.max_length) begin
                        queue_result(KIND_TOO_LONG, '0, '0);
                        state = PH_HUNT;
                    end else if (pay_len == '0) begin
                        state = PH_END;
                    end else begin
                        state = PH_DATA;
                    end
                end
                PH_DATA: begin
                    if (pay_seen < settings.deliver_count)
                        queue_result(KIND_DATA, b, pay_seen);
                    pay_seen = pay_seen + 1'b1;
                    if (pay_seen >= pay_len)
                        state = PH_END;
                end
                PH_END: begin
                    queue_result((b == settings.close_code) ? KIND_GOOD : KIND_BAD_END,
                                 '0, '0);
                    state = PH_HUNT;
                end
                default: begin
                    state = (b == settings.start_code) ? PH_LABEL : PH_HUNT;
                end
            endcase
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            fail_count++;
        endtask

        task check_result(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] data,
                          logic [WORD_W-1:0] idx);
            t_result want;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result kind %0d data %0d index %0d",
                                 kind, data, idx));
                return;
            end
            want = expected_q.pop_front();
            if (kind !== want.kind)
                report($sformatf("kind %0d, expected %0d", kind, want.kind));
            if (data !== want.data_byte)
                report($sformatf("data byte %0d, expected %0d", data, want.data_byte));
            if (idx !== want.byte_index)
                report($sformatf("byte index %0d, expected %0d", idx, want.byte_index));
            kind_count[want.kind]++;
        endtask
    endclass

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [BYTE_W-1:0]   s_axis_tdata  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]  m_axis_tdata;
    logic [KIND_W-1:0]   m_axis_tuser;
    logic                i_cfg_wr_en   = 1'b0;
    logic [ADDR_W-1:0]   i_cfg_addr    = '0;
    logic [WORD_W-1:0]   i_cfg_wdata   = '0;

    frame_scoreboard sb;
    int unsigned     send_idle_pct  = 0;
    int unsigned     recv_stall_pct = 0;
    int unsigned     item_count     = 0;
    int unsigned     quiet_cycles   = 0;
    int unsigned     hold_left      = 0;
    bit              hold_req       = 1'b0;
    bit              hold_taken     = 1'b0;

    always #4 i_clk = ~i_clk;

    labelled_packet_deframer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // result side: check, then decide tready for the next edge
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
            sb.check_result(m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[23:8]);
        if (hold_req && !hold_taken) begin
            hold_left  = HOLD_CYCLES;
            hold_taken = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready === 1'b1) ||
            (m_axis_tvalid === 1'b1 && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic set_idle(idle_mode_e mode);
        case (mode)
            IDLE_SEND: begin
                send_idle_pct  = 54;
                recv_stall_pct = 0;
            end
            IDLE_RECV: begin
                send_idle_pct  = 0;
                recv_stall_pct = 54;
            end
            IDLE_BOTH: begin
                send_idle_pct  = 30;
                recv_stall_pct = 30;
            end
            default: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
        endcase
    endtask

    task automatic send_byte(logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        sb.note_input(b);
        item_count++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [ADDR_W-1:0] addr, logic [WORD_W-1:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        @(posedge i_clk);
    endtask

    task automatic load_settings(t_cfg c);
        write_reg(REG_START_CODE, {8'h00, c.start_code});
        write_reg(REG_CLOSE_CODE, {8'h00, c.close_code});
        write_reg(REG_WANTED_LABEL, {8'h00, c.wanted_label});
        write_reg(REG_MAX_LENGTH, c.max_length);
        write_reg(REG_DELIVER_COUNT, c.deliver_count);
        i_cfg_wr_en <= 1'b0;
        sb.settings = c;
    endtask

    function automatic t_cfg phase_settings(int p);
        t_cfg c;
        c.start_code    = 8'($urandom_range(255));
        c.close_code    = 8'($urandom_range(255));
        c.wanted_label  = ($urandom_range(3) == 0) ? c.start_code : 8'($urandom_range(255));
        c.max_length    = ($urandom_range(4) == 0) ? 16'hFFFF : 16'($urandom_range(30));
        c.deliver_count = ($urandom_range(4) == 0) ? 16'hFFFF : 16'($urandom_range(15));
        case (p)
            0: c = '{RST_START_CODE, RST_CLOSE_CODE, RST_WANTED_LABEL,
                     RST_MAX_LENGTH, RST_DELIVER_COUNT};
            1: c = '{8'h00, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF};
            2: c = '{8'hFF, 8'h00, 8'h00, 16'h0000, 16'h0000};
            4: c = '{8'h55, 8'h55, 8'h55, 16'd8, 16'd3};
            default: ;
        endcase
        return c;
    endfunction

    // mostly whole packets; some noise, wrong labels, oversize lengths, bad end codes
    task automatic send_frame();
        t_cfg              s;
        int unsigned       len;
        int unsigned       cap;
        int unsigned       pick;
        logic [BYTE_W-1:0] b;
        s    = sb.settings;
        pick = $urandom_range(99);
        if (pick < 8) begin
            repeat ($urandom_range(1, 3)) begin
                do b = 8'($urandom_range(255)); while (b == s.start_code);
                send_byte(b);
            end
            return;
        end
        send_byte(s.start_code);
        if (pick < 16 && s.wanted_label != s.start_code)
            send_byte(s.start_code);
        if (pick >= 16 && pick < 24) begin
            do b = 8'($urandom_range(255)); while (b == s.wanted_label || b == s.start_code);
            send_byte(b);
            return;
        end
        send_byte(s.wanted_label);
        cap = (s.max_length < 12) ? 32'(s.max_length) : 12;
        if (pick >= 24 && pick < 34 && s.max_length != 16'hFFFF)
            len = $urandom_range(65535, s.max_length + 1);
        else if (pick >= 34 && pick < 40 && s.max_length <= 64)
            len = 32'(s.max_length);
        else
            len = $urandom_range(cap);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        if (len > s.max_length)
            return;
        repeat (len) send_byte(8'($urandom_range(255)));
        b = s.close_code;
        if ($urandom_range(6) == 0)
            do b = 8'($urandom_range(255)); while (b == s.close_code);
        send_byte(b);
    endtask

    initial begin
        t_cfg        c;
        int unsigned target;
        sb = new();
        set_idle(IDLE_NONE);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // noise, repeated start code, two-byte packet, wrong label
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(RST_START_CODE);
        send_byte(RST_START_CODE);
        send_byte(RST_WANTED_LABEL);
        send_byte(8'd2);
        send_byte(8'd0);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(RST_CLOSE_CODE);
        send_byte(RST_START_CODE);
        send_byte(8'd6);
        // zero length with bad end code, then an oversize length
        send_byte(RST_START_CODE);
        send_byte(RST_WANTED_LABEL);
        send_byte(8'd0);
        send_byte(8'd0);
        send_byte(8'h00);
        send_byte(RST_START_CODE);
        send_byte(RST_WANTED_LABEL);
        send_byte(8'hFF);
        send_byte(8'hFF);
        wait_idle();

        // label equal to start code, payload past the deliver count
        c = '{8'h00, 8'hFF, 8'h00, 16'd3, 16'd1};
        load_settings(c);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'd3);
        send_byte(8'd0);
        send_byte(8'hA5);
        send_byte(8'h5A);
        send_byte(8'hC3);
        send_byte(8'hFF);

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_idle();
            load_settings(phase_settings(p));
            set_idle(idle_mode_e'(p % 4));
            if (p == 0)
                hold_req = 1'b1;
            target = item_count + PHASE_ITEMS;
            while (item_count < target)
                send_frame();
        end
        wait_idle();

        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected results never arrived", sb.pending()));
        $display("sent %0d bytes under %0d register settings, %0d payload bytes checked",
                 item_count, NUM_PHASES + 2, sb.kind_count[KIND_DATA]);
        $display("frames good %0d, bad end code %0d, length too long %0d",
                 sb.kind_count[KIND_GOOD], sb.kind_count[KIND_BAD_END],
                 sb.kind_count[KIND_TOO_LONG]);
        if (sb.fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
